@@ hdl/heightmap_vertex_normal_assert.svh @@
// Assertion macros for the heightmap vertex normal block.
// Each use needs clk and arst_n in scope.
`ifndef HEIGHTMAP_VERTEX_NORMAL_ASSERT_SVH
`define HEIGHTMAP_VERTEX_NORMAL_ASSERT_SVH

// cond must never hold outside reset
`define HVN_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("hvn: forbidden condition seen");

// whenever trig holds, expr holds in the same cycle
`define HVN_IMPLIES(lbl, trig, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (expr)) \
		else $error("hvn: implication failed");

`endif

@@ hdl/hvn_pkg.sv @@
package hvn_pkg;

	localparam int POS_W  = 14;
	localparam int HGT_W  = 16;
	localparam int DIM_W  = 15;
	localparam int FACES  = 6;
	localparam int CELLS  = 4;
	localparam int DIFF_W = HGT_W + 1;
	localparam int SQ_W   = 2 * DIFF_W;

	// square root unit: 64-bit radicand, 32-bit root, one stage per root bit
	localparam int RAD_W     = 64;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int SQ_LAT    = ROOT_W + 1;
	localparam int RAD_SHIFT = 28;
	localparam int NRM_SHIFT = 8;
	localparam int L2_BIAS   = 65536;

	// divider: rounded, signed result from magnitude and sign
	localparam int DIV_NUM_W = 55;
	localparam int DIV_REM_W = DIV_NUM_W + 1;
	localparam int DIV_DEN_W = ROOT_W;
	localparam int DIV_QW    = 25;
	localparam int QUO_W     = DIV_QW + 1;
	localparam int DIV_LAT   = DIV_QW + 2;

	localparam int FACE_FRAC = 38;
	localparam int OUT_FRAC  = 18;
	localparam int Z_FACE    = 256;
	localparam int SUM_W     = 29;
	localparam int SSQ_W     = 2 * SUM_W;
	localparam int ONE_Q14   = 16384;
	localparam int NX_W      = 16;
	localparam int NZ_W      = 15;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

	localparam int FIFO_DEPTH = 2;

	typedef enum logic [0:0] {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic             valid;
		cfg_reg_t         index;
		logic [DIM_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [POS_W-1:0] x_pos;
		logic [POS_W-1:0] y_pos;
		logic [HGT_W-1:0] h_center;
		logic [HGT_W-1:0] h_left;
		logic [HGT_W-1:0] h_right;
		logic [HGT_W-1:0] h_up;
		logic [HGT_W-1:0] h_up_left;
		logic [HGT_W-1:0] h_down;
		logic [HGT_W-1:0] h_down_right;
	} vtx_t;

	// classified item: which cells take part, and the two slopes of each face
	typedef struct packed {
		logic [CELLS-1:0]              cells;
		logic [FACES-1:0][DIFF_W-1:0]  dx;
		logic [FACES-1:0][DIFF_W-1:0]  dy;
	} item_t;

endpackage

@@ hdl/hvn_front.sv @@
module hvn_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  hvn_pkg::vtx_t   vtx,
	input  hvn_pkg::cfg_wr_t cfg,
	input  logic            q_full,
	output logic            q_push,
	output hvn_pkg::item_t  q_item
);
	import hvn_pkg::*;

	logic [DIM_W-1:0] grid_w_q, grid_h_q;
	logic             vld_s1;
	item_t            item_s1;
	item_t            item_d;
	logic             accept;
	logic [DIM_W-1:0] xe, ye, xp1, yp1;
	logic             x_nz, y_nz;

	function automatic logic [DIFF_W-1:0] hdiff(input logic [HGT_W-1:0] a,
			input logic [HGT_W-1:0] b);
		return {a[HGT_W-1], a} - {b[HGT_W-1], b};
	endfunction

	assign q_push = vld_s1 && !q_full;
	assign busy   = vld_s1 && q_full;
	assign accept = start && !busy;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= DIM_RESET;
			grid_h_q <= DIM_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_GRID_WIDTH:  grid_w_q <= cfg.data;
				REG_GRID_HEIGHT: grid_h_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		xe   = {1'b0, vtx.x_pos};
		ye   = {1'b0, vtx.y_pos};
		xp1  = xe + DIM_W'(1);
		yp1  = ye + DIM_W'(1);
		x_nz = (vtx.x_pos != '0);
		y_nz = (vtx.y_pos != '0);
		// cells (x,y), (x-1,y-1), (x-1,y) left face, (x,y-1) right face
		item_d.cells[0] = (xp1 < grid_w_q) && (yp1 < grid_h_q);
		item_d.cells[1] = x_nz && y_nz && (xe < grid_w_q) && (ye < grid_h_q);
		item_d.cells[2] = x_nz && (xe < grid_w_q) && (yp1 < grid_h_q);
		item_d.cells[3] = y_nz && (xp1 < grid_w_q) && (ye < grid_h_q);
		item_d.dx[0] = hdiff(vtx.h_center, vtx.h_right);
		item_d.dy[0] = hdiff(vtx.h_right, vtx.h_down_right);
		item_d.dx[1] = hdiff(vtx.h_down, vtx.h_down_right);
		item_d.dy[1] = hdiff(vtx.h_center, vtx.h_down);
		item_d.dx[2] = hdiff(vtx.h_up_left, vtx.h_up);
		item_d.dy[2] = hdiff(vtx.h_up, vtx.h_center);
		item_d.dx[3] = hdiff(vtx.h_left, vtx.h_center);
		item_d.dy[3] = hdiff(vtx.h_up_left, vtx.h_left);
		item_d.dx[4] = hdiff(vtx.h_left, vtx.h_center);
		item_d.dy[4] = hdiff(vtx.h_center, vtx.h_down);
		item_d.dx[5] = hdiff(vtx.h_center, vtx.h_right);
		item_d.dy[5] = hdiff(vtx.h_up, vtx.h_center);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

@@ hdl/hvn_fifo.sv @@
module hvn_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hvn_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output hvn_pkg::item_t head_item
);
	import hvn_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	item_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ hdl/hvn_sqrt.sv @@
module hvn_sqrt (
	input  logic                        clk,
	input  logic [hvn_pkg::RAD_W-1:0]  rad,
	output logic [hvn_pkg::ROOT_W-1:0] root
);
	import hvn_pkg::*;

	// floor square root, one root bit per stage
	logic [RAD_W-1:0] n_q [ROOT_W+1];
	logic [RAD_W-1:0] r_q [ROOT_W+1];
	logic [RAD_W-1:0] n_d [ROOT_W];
	logic [RAD_W-1:0] r_d [ROOT_W];
	logic [RAD_W-1:0] bit_c [ROOT_W];
	logic [RAD_W:0]   trial [ROOT_W];

	always_comb begin
		for (int k = 0; k < ROOT_W; k++) begin
			bit_c[k] = RAD_W'(1) << (RAD_W - 2 - 2 * k);
			trial[k] = {1'b0, r_q[k]} + {1'b0, bit_c[k]};
			if ({1'b0, n_q[k]} >= trial[k]) begin
				n_d[k] = n_q[k] - trial[k][RAD_W-1:0];
				r_d[k] = (r_q[k] >> 1) + bit_c[k];
			end else begin
				n_d[k] = n_q[k];
				r_d[k] = r_q[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		n_q[0] <= rad;
		r_q[0] <= '0;
		for (int k = 0; k < ROOT_W; k++) begin
			n_q[k+1] <= n_d[k];
			r_q[k+1] <= r_d[k];
		end
	end

	assign root = r_q[ROOT_W][ROOT_W-1:0];

endmodule

@@ hdl/hvn_div.sv @@
module hvn_div (
	input  logic                               clk,
	input  logic                               neg,
	input  logic [hvn_pkg::DIV_NUM_W-1:0]      mag,
	input  logic [hvn_pkg::DIV_DEN_W-1:0]      den,
	output logic signed [hvn_pkg::QUO_W-1:0]   quo
);
	import hvn_pkg::*;

	// restoring divide of (mag + den/2) by den, one quotient bit per stage
	logic [DIV_REM_W-1:0] rem_q [DIV_QW+1];
	logic [DIV_DEN_W-1:0] den_q [DIV_QW+1];
	logic [DIV_QW-1:0]    quo_q [DIV_QW+1];
	logic                 neg_q [DIV_QW+1];
	logic [DIV_REM_W:0]   diff [DIV_QW];
	logic [DIV_REM_W:0]   dsh [DIV_QW];
	logic signed [QUO_W-1:0] res_q;

	always_comb begin
		for (int k = 0; k < DIV_QW; k++) begin
			dsh[k]  = (DIV_REM_W + 1)'(den_q[k]) << (DIV_QW - 1 - k);
			diff[k] = {1'b0, rem_q[k]} - dsh[k];
		end
	end

	always_ff @(posedge clk) begin
		rem_q[0] <= DIV_REM_W'(mag) + DIV_REM_W'(den >> 1);
		den_q[0] <= den;
		quo_q[0] <= '0;
		neg_q[0] <= neg;
		for (int k = 0; k < DIV_QW; k++) begin
			rem_q[k+1] <= diff[k][DIV_REM_W] ? rem_q[k] : diff[k][DIV_REM_W-1:0];
			quo_q[k+1] <= {quo_q[k][DIV_QW-2:0], ~diff[k][DIV_REM_W]};
			den_q[k+1] <= den_q[k];
			neg_q[k+1] <= neg_q[k];
		end
		res_q <= neg_q[DIV_QW] ? -$signed({1'b0, quo_q[DIV_QW]})
			: $signed({1'b0, quo_q[DIV_QW]});
	end

	assign quo = res_q;

endmodule

@@ hdl/hvn_back.sv @@
module hvn_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  hvn_pkg::item_t                  in_item,
	output logic                            done,
	output logic signed [hvn_pkg::NX_W-1:0] normal_x,
	output logic signed [hvn_pkg::NX_W-1:0] normal_y,
	output logic [hvn_pkg::NZ_W-1:0]        normal_z
);
	import hvn_pkg::*;

	localparam int FACE_DLY = SQ_LAT + DIV_LAT;
	localparam int FACE_CELL [FACES] = '{0, 0, 1, 1, 2, 3};
	localparam logic [DIV_NUM_W-1:0] Z_NUM = DIV_NUM_W'(Z_FACE) << FACE_FRAC;

	function automatic logic [SQ_W-1:0] sq_diff(input logic [DIFF_W-1:0] d);
		logic signed [SQ_W-1:0] e;
		e = $signed({{(SQ_W-DIFF_W){d[DIFF_W-1]}}, d});
		return SQ_W'(e * e);
	endfunction

	function automatic logic [SSQ_W-1:0] sq_sum(input logic signed [SUM_W-1:0] s);
		logic signed [SSQ_W-1:0] e;
		e = {{(SSQ_W-SUM_W){s[SUM_W-1]}}, s};
		return SSQ_W'(e * e);
	endfunction

	function automatic logic signed [NX_W-1:0] clamp_q14(input logic signed [QUO_W-1:0] v);
		if (v > QUO_W'(ONE_Q14)) begin
			return NX_W'(ONE_Q14);
		end else if (v < -QUO_W'(ONE_Q14)) begin
			return -NX_W'(ONE_Q14);
		end
		return v[NX_W-1:0];
	endfunction

	// face stage: slopes and their squares
	logic                vld_s1;
	logic [CELLS-1:0]    cells_s1;
	logic [DIFF_W-1:0]   dx_s1 [FACES];
	logic [DIFF_W-1:0]   dy_s1 [FACES];
	logic [SQ_W-1:0]     sqx_s1 [FACES];
	logic [SQ_W-1:0]     sqy_s1 [FACES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		cells_s1 <= in_item.cells;
		for (int f = 0; f < FACES; f++) begin
			dx_s1[f]  <= in_item.dx[f];
			dy_s1[f]  <= in_item.dy[f];
			sqx_s1[f] <= sq_diff(in_item.dx[f]);
			sqy_s1[f] <= sq_diff(in_item.dy[f]);
		end
	end

	// face length, slopes wait alongside
	logic [SQ_W-1:0]   l2 [FACES];
	logic [RAD_W-1:0]  frad [FACES];
	logic [ROOT_W-1:0] flen [FACES];
	logic [DIFF_W-1:0] dxd_q [SQ_LAT][FACES];
	logic [DIFF_W-1:0] dyd_q [SQ_LAT][FACES];

	always_comb begin
		for (int f = 0; f < FACES; f++) begin
			l2[f]   = sqx_s1[f] + sqy_s1[f] + SQ_W'(L2_BIAS);
			frad[f] = RAD_W'(l2[f]) << RAD_SHIFT;
		end
	end

	always_ff @(posedge clk) begin
		dxd_q[0] <= dx_s1;
		dyd_q[0] <= dy_s1;
		for (int i = 1; i < SQ_LAT; i++) begin
			dxd_q[i] <= dxd_q[i-1];
			dyd_q[i] <= dyd_q[i-1];
		end
	end

	logic [DIFF_W-1:0]       dxa [FACES];
	logic [DIFF_W-1:0]       dya [FACES];
	logic signed [QUO_W-1:0] cx [FACES];
	logic signed [QUO_W-1:0] cy [FACES];
	logic signed [QUO_W-1:0] cz [FACES];

	for (genvar f = 0; f < FACES; f++) begin : g_face
		logic [DIFF_W-1:0] dxl, dyl;
		assign dxl    = dxd_q[SQ_LAT-1][f];
		assign dyl    = dyd_q[SQ_LAT-1][f];
		assign dxa[f] = dxl[DIFF_W-1] ? -dxl : dxl;
		assign dya[f] = dyl[DIFF_W-1] ? -dyl : dyl;

		hvn_sqrt u_sqrt (.clk(clk), .rad(frad[f]), .root(flen[f]));

		hvn_div u_div_x (
			.clk(clk), .neg(dxl[DIFF_W-1]),
			.mag(DIV_NUM_W'(dxa[f]) << FACE_FRAC), .den(flen[f]), .quo(cx[f])
		);
		hvn_div u_div_y (
			.clk(clk), .neg(dyl[DIFF_W-1]),
			.mag(DIV_NUM_W'(dya[f]) << FACE_FRAC), .den(flen[f]), .quo(cy[f])
		);
		hvn_div u_div_z (
			.clk(clk), .neg(1'b0), .mag(Z_NUM), .den(flen[f]), .quo(cz[f])
		);
	end

	// cell flags follow the face lanes
	logic [FACE_DLY-1:0] vfd_q;
	logic [CELLS-1:0]    cfd_q [FACE_DLY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vfd_q <= '0;
		end else begin
			vfd_q <= {vfd_q[FACE_DLY-2:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		cfd_q[0] <= cells_s1;
		for (int i = 1; i < FACE_DLY; i++) begin
			cfd_q[i] <= cfd_q[i-1];
		end
	end

	// vertex sum over the faces that take part
	logic signed [SUM_W-1:0] acc [3];
	logic signed [SUM_W-1:0] sum_s2 [3];
	logic                    any_s2, vld_s2;
	logic [CELLS-1:0]        cl;

	always_comb begin
		cl = cfd_q[FACE_DLY-1];
		for (int c = 0; c < 3; c++) begin
			acc[c] = '0;
		end
		for (int f = 0; f < FACES; f++) begin
			if (cl[FACE_CELL[f]]) begin
				acc[0] = acc[0] + SUM_W'(cx[f]);
				acc[1] = acc[1] + SUM_W'(cy[f]);
				acc[2] = acc[2] + SUM_W'(cz[f]);
			end
		end
	end

	logic signed [SUM_W-1:0] sum_s3 [3];
	logic [SSQ_W-1:0]        sq_s3 [3];
	logic                    any_s3, vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= vfd_q[FACE_DLY-1];
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= acc;
		any_s2 <= |cl;
		sum_s3 <= sum_s2;
		any_s3 <= any_s2;
		for (int c = 0; c < 3; c++) begin
			sq_s3[c] <= sq_sum(sum_s2[c]);
		end
	end

	// vertex length
	logic [SSQ_W-1:0]  qsum;
	logic [RAD_W-1:0]  vrad;
	logic [ROOT_W-1:0] vlen;

	assign qsum = sq_s3[0] + sq_s3[1] + sq_s3[2];
	assign vrad = RAD_W'(qsum) << NRM_SHIFT;

	hvn_sqrt u_sqrt_v (.clk(clk), .rad(vrad), .root(vlen));

	logic signed [SUM_W-1:0] sd_q [SQ_LAT][3];
	logic                    ad_q [SQ_LAT];
	logic [SQ_LAT-1:0]       vsd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vsd_q <= '0;
		end else begin
			vsd_q <= {vsd_q[SQ_LAT-2:0], vld_s3};
		end
	end

	always_ff @(posedge clk) begin
		sd_q[0] <= sum_s3;
		ad_q[0] <= any_s3;
		for (int i = 1; i < SQ_LAT; i++) begin
			sd_q[i] <= sd_q[i-1];
			ad_q[i] <= ad_q[i-1];
		end
	end

	logic signed [QUO_W-1:0] nq [3];

	for (genvar c = 0; c < 3; c++) begin : g_out
		logic signed [SUM_W-1:0] sv;
		logic [SUM_W-1:0]        sa;
		assign sv = sd_q[SQ_LAT-1][c];
		assign sa = sv[SUM_W-1] ? -sv : sv;

		hvn_div u_div_n (
			.clk(clk), .neg(sv[SUM_W-1]),
			.mag(DIV_NUM_W'(sa) << OUT_FRAC), .den(vlen), .quo(nq[c])
		);
	end

	logic [DIV_LAT-1:0] vnd_q;
	logic [DIV_LAT-1:0] and_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vnd_q <= '0;
		end else begin
			vnd_q <= {vnd_q[DIV_LAT-2:0], vsd_q[SQ_LAT-1]};
		end
	end

	always_ff @(posedge clk) begin
		and_q <= {and_q[DIV_LAT-2:0], ad_q[SQ_LAT-1]};
	end

	// result register
	logic signed [NX_W-1:0] nz_c;
	logic                   done_q;
	logic signed [NX_W-1:0] nx_q, ny_q;
	logic [NZ_W-1:0]        nz_q;

	assign nz_c = clamp_q14(nq[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vnd_q[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (and_q[DIV_LAT-1]) begin
			nx_q <= clamp_q14(nq[0]);
			ny_q <= clamp_q14(nq[1]);
			nz_q <= nz_c[NX_W-1] ? '0 : nz_c[NZ_W-1:0];
		end else begin
			// no cell in the grid: up vector
			nx_q <= '0;
			ny_q <= '0;
			nz_q <= NZ_W'(ONE_Q14);
		end
	end

	assign done     = done_q;
	assign normal_x = nx_q;
	assign normal_y = ny_q;
	assign normal_z = nz_q;

endmodule

@@ hdl/heightmap_vertex_normal.sv @@
// Channel    Transfer when             Carries
// --------   -----------------------   -----------------------------------------
// vertex     start & !busy             x_pos, y_pos, seven Q8.8 heights
// result     done (one cycle)          normal_x, normal_y, normal_z (Q1.14)
// config     cfg_valid & cfg_ready     cfg_index, cfg_data (grid_width/height)
//
// One vertex is taken per clock while busy is low; results come out in order
// behind the 33-stage square root and 27-stage divider pipelines, passed at
// face and at vertex level. Reset (arst_n low) clears all control state and
// sets both grid dimensions to 256. The receiver cannot stall; busy rises
// only if the front-to-back queue fills, which the back end, draining one
// entry every cycle, never lets happen. cfg_ready is always high.
`include "heightmap_vertex_normal_assert.svh"

module heightmap_vertex_normal (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [hvn_pkg::POS_W-1:0]       x_pos,
	input  logic [hvn_pkg::POS_W-1:0]       y_pos,
	input  logic signed [hvn_pkg::HGT_W-1:0] h_center,
	input  logic signed [hvn_pkg::HGT_W-1:0] h_left,
	input  logic signed [hvn_pkg::HGT_W-1:0] h_right,
	input  logic signed [hvn_pkg::HGT_W-1:0] h_up,
	input  logic signed [hvn_pkg::HGT_W-1:0] h_up_left,
	input  logic signed [hvn_pkg::HGT_W-1:0] h_down,
	input  logic signed [hvn_pkg::HGT_W-1:0] h_down_right,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [0:0]                      cfg_index,
	input  logic [hvn_pkg::DIM_W-1:0]       cfg_data,
	output logic                            done,
	output logic signed [hvn_pkg::NX_W-1:0] normal_x,
	output logic signed [hvn_pkg::NX_W-1:0] normal_y,
	output logic [hvn_pkg::NZ_W-1:0]        normal_z
);
	import hvn_pkg::*;

	vtx_t    vtx;
	cfg_wr_t cfg;
	item_t   push_item, head_item;
	logic    q_full, q_push, head_valid;

	// config registers take a write every cycle
	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_reg_t'(cfg_index);
	assign cfg.data  = cfg_data;

	assign vtx.x_pos        = x_pos;
	assign vtx.y_pos        = y_pos;
	assign vtx.h_center     = h_center;
	assign vtx.h_left       = h_left;
	assign vtx.h_right      = h_right;
	assign vtx.h_up         = h_up;
	assign vtx.h_up_left    = h_up_left;
	assign vtx.h_down       = h_down;
	assign vtx.h_down_right = h_down_right;

	// front: accept, find contributing cells, form face slopes
	hvn_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vtx(vtx), .cfg(cfg), .q_full(q_full), .q_push(q_push), .q_item(push_item)
	);

	// queue between front and back; the back end takes the head every cycle
	hvn_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_item(push_item),
		.full(q_full), .pop(head_valid), .head_valid(head_valid),
		.head_item(head_item)
	);

	// back: face normals, vertex sum, normalize
	hvn_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(head_valid), .in_item(head_item),
		.done(done), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
	);

	`HVN_NEVER(a_queue_never_full, busy)
	`HVN_IMPLIES(a_nx_range, done, (normal_x <= 16'sd16384) && (normal_x >= -16'sd16384))
	`HVN_IMPLIES(a_ny_range, done, (normal_y <= 16'sd16384) && (normal_y >= -16'sd16384))
	`HVN_IMPLIES(a_nz_range, done, normal_z <= 15'd16384)

endmodule
